[design/sars_pkg.sv]
// Shared types and constants for the suffix array range search block.
package sars_pkg;

    localparam int TEXT_DEPTH_DEF    = 65536;
    localparam int PATTERN_DEPTH_DEF = 4096;
    localparam logic [7:0] FULL_MASK = 8'hFF;

    typedef enum logic [1:0] {
        OP_TEXT    = 2'd0,
        OP_SUFFIX  = 2'd1,
        OP_PATTERN = 2'd2,
        OP_SEARCH  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LOOP,
        S_SUF_RD,
        S_SUF_LAT,
        S_BYTE_CHK,
        S_BYTE_CMP,
        S_STEP,
        S_DECIDE,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_LOW,
        PH_HIGH
    } phase_t;

    typedef struct packed {
        logic accept_write;
        logic accept_search;
        logic res_err;
        logic res_all;
        logic init_exact;
        logic init_mask_all;
        logic init_mask_res;
        logic suf_latch;
        logic chk_end;
        logic cmp_latch;
        logic j_inc;
        logic step_right;
        logic step_left;
        logic step_split;
        logic main_done;
        logic low_done;
        logic high_done;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic plen_big;
        logic plen_zero;
        logic plen_one;
        logic mask_full;
        logic size_zero;
        logic byte_cond;
        logic byte_diff;
        logic sign_neg;
        logic sign_zero;
        logic mask_stage;
        logic then_mask;
        logic cnt_nonzero;
    } stat_t;

endpackage

[design/sars_ram.sv]
// Generic simple dual-port RAM with a registered read.
module sars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/sars_ctrl.sv]
// Sequencer for loads and for the bound searches of a search item.
module sars_ctrl import sars_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  op_t   s_op,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_MAIN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and search phase.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_op == OP_SEARCH) state_next = S_START;
            end
            S_START: begin
                phase_next = PH_MAIN;
                if (stat.plen_big || stat.plen_zero) state_next = S_FIN;
                else state_next = S_LOOP;
            end
            S_LOOP: begin
                if (stat.size_zero) begin
                    unique case (phase_reg)
                        PH_LOW: begin
                            phase_next = PH_HIGH;
                            state_next = S_LOOP;
                        end
                        default: state_next = S_DECIDE;
                    endcase
                end else begin
                    state_next = S_SUF_RD;
                end
            end
            S_SUF_RD:   state_next = S_SUF_LAT;
            S_SUF_LAT:  state_next = S_BYTE_CHK;
            S_BYTE_CHK: state_next = stat.byte_cond ? S_BYTE_CMP : S_STEP;
            S_BYTE_CMP: state_next = stat.byte_diff ? S_STEP : S_BYTE_CHK;
            S_STEP: begin
                if (phase_reg == PH_MAIN && stat.sign_zero) phase_next = PH_LOW;
                state_next = S_LOOP;
            end
            S_DECIDE: begin
                if (!stat.mask_stage && stat.then_mask && stat.cnt_nonzero) begin
                    phase_next = PH_MAIN;
                    state_next = S_LOOP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!out_valid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd = '0;
        s_tready = (state_reg == S_IDLE);
        m_tvalid = out_valid_reg;
        out_valid_next = (m_tready) ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.accept_search = s_tvalid && s_op == OP_SEARCH;
                cmd.accept_write  = s_tvalid && s_op != OP_SEARCH;
            end
            S_START: begin
                if (stat.plen_big) cmd.res_err = 1'b1;
                else if (stat.plen_zero) cmd.res_all = 1'b1;
                else if (!stat.mask_full && stat.plen_one) cmd.init_mask_all = 1'b1;
                else cmd.init_exact = 1'b1;
            end
            S_LOOP: begin
                if (stat.size_zero) begin
                    unique case (phase_reg)
                        PH_MAIN: cmd.main_done = 1'b1;
                        PH_LOW:  cmd.low_done  = 1'b1;
                        default: cmd.high_done = 1'b1;
                    endcase
                end
            end
            S_SUF_RD: ;
            S_SUF_LAT: cmd.suf_latch = 1'b1;
            S_BYTE_CHK: cmd.chk_end = !stat.byte_cond;
            S_BYTE_CMP: begin
                cmd.cmp_latch = stat.byte_diff;
                cmd.j_inc     = !stat.byte_diff;
            end
            S_STEP: begin
                unique case (phase_reg)
                    PH_MAIN: begin
                        cmd.step_right = stat.sign_neg;
                        cmd.step_split = stat.sign_zero;
                        cmd.step_left  = !stat.sign_neg && !stat.sign_zero;
                    end
                    PH_LOW: begin
                        cmd.step_right = stat.sign_neg;
                        cmd.step_left  = !stat.sign_neg;
                    end
                    default: begin
                        cmd.step_right = stat.sign_neg || stat.sign_zero;
                        cmd.step_left  = !(stat.sign_neg || stat.sign_zero);
                    end
                endcase
            end
            S_DECIDE: begin
                cmd.init_mask_res = !stat.mask_stage && stat.then_mask && stat.cnt_nonzero;
            end
            S_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

[design/sars_dp.sv]
// Datapath: stores, search bounds, byte compare and result registers.
module sars_dp import sars_pkg::*; #(
    parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  op_t         s_op,
    input  logic [15:0] s_address,
    input  logic [15:0] s_write_data,
    input  logic [12:0] s_pattern_length,
    input  logic [7:0]  s_last_mask,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic [16:0] m_first_index,
    output logic [16:0] m_hit_count,
    output logic        m_status
);

    localparam int TA = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int PA = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int CW = $clog2(TEXT_DEPTH + 1);
    localparam int PW = $clog2(PATTERN_DEPTH + 1);

    logic [16:0]   text_length_reg;
    logic [CW-1:0] len;

    logic [PW-1:0] plen_reg, end_reg, cmp_j_reg, lo_reg, hi_reg, sl_reg, sh_reg;
    logic          plen_big_reg, mask_stage_reg, then_mask_reg;
    logic          sign_neg_reg, sign_zero_reg;
    logic [7:0]    mask_reg;
    logic [CW-1:0] start_reg, base_reg, size_reg, i_reg, j_reg, sk_reg, ss_reg;
    logic [CW-1:0] res_idx_reg, res_cnt_reg, half, cnt;
    logic          res_status_reg;
    logic [15:0]   suf_reg;
    logic [16:0]   out_idx_reg, out_cnt_reg;
    logic          out_status_reg;

    logic [7:0]    text_rdata, pat_rdata, tmasked;
    logic [15:0]   suf_rdata;
    logic [31:0]   text_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_length_reg <= '0;
        end else if (cfg_we) begin
            text_length_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (32'(text_length_reg) > 32'(TEXT_DEPTH)) len = CW'(TEXT_DEPTH);
        else len = CW'(text_length_reg);
    end

    // Stores.
    sars_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
        .aclk  (aclk),
        .we    (cmd.accept_write && s_op == OP_TEXT && 32'(s_address) < 32'(TEXT_DEPTH)),
        .waddr (TA'(s_address)),
        .wdata (s_write_data[7:0]),
        .raddr (TA'(text_pos)),
        .rdata (text_rdata)
    );

    sars_ram #(.WIDTH(16), .DEPTH(TEXT_DEPTH)) u_suffix (
        .aclk  (aclk),
        .we    (cmd.accept_write && s_op == OP_SUFFIX && 32'(s_address) < 32'(TEXT_DEPTH)),
        .waddr (TA'(s_address)),
        .wdata (s_write_data),
        .raddr (TA'(start_reg + base_reg + half)),
        .rdata (suf_rdata)
    );

    sars_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pattern (
        .aclk  (aclk),
        .we    (cmd.accept_write && s_op == OP_PATTERN &&
                32'(s_address) < 32'(PATTERN_DEPTH)),
        .waddr (PA'(s_address)),
        .wdata (s_write_data[7:0]),
        .raddr (PA'(cmp_j_reg)),
        .rdata (pat_rdata)
    );

    assign half     = size_reg >> 1;
    assign text_pos = 32'(suf_reg) + 32'(cmp_j_reg);
    assign tmasked  = text_rdata & (mask_stage_reg ? mask_reg : FULL_MASK);
    assign cnt      = base_reg - j_reg;

    always_comb begin
        stat.plen_big    = plen_big_reg;
        stat.plen_zero   = (plen_reg == '0);
        stat.plen_one    = (plen_reg == PW'(1));
        stat.mask_full   = (mask_reg == FULL_MASK);
        stat.size_zero   = (size_reg == '0);
        stat.byte_cond   = (cmp_j_reg < end_reg) && (text_pos < 32'(len));
        stat.byte_diff   = (tmasked != pat_rdata);
        stat.sign_neg    = sign_neg_reg;
        stat.sign_zero   = sign_zero_reg;
        stat.mask_stage  = mask_stage_reg;
        stat.then_mask   = then_mask_reg;
        stat.cnt_nonzero = (res_cnt_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_search) begin
            plen_big_reg <= 32'(s_pattern_length) > 32'(PATTERN_DEPTH);
            plen_reg     <= PW'(s_pattern_length);
            mask_reg     <= s_last_mask;
        end
        if (cmd.res_err) begin
            res_idx_reg    <= '0;
            res_cnt_reg    <= '0;
            res_status_reg <= 1'b1;
        end
        if (cmd.res_all) begin
            res_idx_reg    <= '0;
            res_cnt_reg    <= len;
            res_status_reg <= 1'b0;
        end
        if (cmd.init_exact) begin
            start_reg      <= '0;
            base_reg       <= '0;
            size_reg       <= len;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mask_stage_reg <= 1'b0;
            then_mask_reg  <= (mask_reg != FULL_MASK);
            end_reg        <= (mask_reg == FULL_MASK) ? plen_reg : plen_reg - PW'(1);
            res_status_reg <= 1'b0;
        end
        if (cmd.init_mask_all) begin
            start_reg      <= '0;
            base_reg       <= '0;
            size_reg       <= len;
            mask_stage_reg <= 1'b1;
            end_reg        <= plen_reg;
            res_status_reg <= 1'b0;
        end
        if (cmd.init_mask_res) begin
            start_reg      <= res_idx_reg;
            base_reg       <= '0;
            size_reg       <= res_cnt_reg;
            mask_stage_reg <= 1'b1;
            end_reg        <= plen_reg;
        end
        // The masked stage always compares the last pattern byte only.
        if (cmd.suf_latch) begin
            suf_reg <= suf_rdata;
            if (mask_stage_reg) cmp_j_reg <= end_reg - PW'(1);
            else cmp_j_reg <= (lo_reg < hi_reg) ? lo_reg : hi_reg;
        end
        if (cmd.j_inc) cmp_j_reg <= cmp_j_reg + PW'(1);
        // Running out of text or pattern: less unless all bytes up to end_reg matched.
        if (cmd.chk_end) begin
            sign_neg_reg  <= (cmp_j_reg != end_reg);
            sign_zero_reg <= (cmp_j_reg == end_reg);
        end
        if (cmd.cmp_latch) begin
            sign_neg_reg  <= (tmasked < pat_rdata);
            sign_zero_reg <= 1'b0;
        end
        if (cmd.step_right) begin
            base_reg <= base_reg + half + CW'(1);
            size_reg <= size_reg - half - CW'(1);
            lo_reg   <= cmp_j_reg;
        end
        if (cmd.step_left) begin
            size_reg <= half;
            hi_reg   <= cmp_j_reg;
        end
        if (cmd.step_split) begin
            i_reg    <= base_reg;
            sk_reg   <= base_reg + half + CW'(1);
            ss_reg   <= size_reg - half - CW'(1);
            sl_reg   <= cmp_j_reg;
            sh_reg   <= hi_reg;
            size_reg <= half;
            hi_reg   <= cmp_j_reg;
        end
        if (cmd.main_done) begin
            res_idx_reg <= start_reg + base_reg;
            res_cnt_reg <= '0;
        end
        if (cmd.low_done) begin
            j_reg    <= base_reg;
            base_reg <= sk_reg;
            size_reg <= ss_reg;
            lo_reg   <= sl_reg;
            hi_reg   <= sh_reg;
        end
        if (cmd.high_done) begin
            res_cnt_reg <= cnt;
            res_idx_reg <= start_reg + ((cnt != '0) ? j_reg : i_reg);
        end
        if (cmd.load_out) begin
            out_idx_reg    <= 17'(res_idx_reg);
            out_cnt_reg    <= 17'(res_cnt_reg);
            out_status_reg <= res_status_reg;
        end
    end

    assign m_first_index = out_idx_reg;
    assign m_hit_count   = out_cnt_reg;
    assign m_status      = out_status_reg;

endmodule

[design/suffix_array_range_search.sv]
// Suffix array range search: top level joining sequencer and datapath.
// A store write transfer is taken in S_IDLE and the block is ready again at once.
// A search runs binary steps over the suffix array; each step reads one suffix entry and
// then runs the byte compare loop that reads one text byte and one pattern byte per
// turn.
// One search is in flight at a time; its result waits in an output register.
// Reset is synchronous, active low: clears the sequencer and text_length; stores keep data.
module suffix_array_range_search import sars_pkg::*; #(
    parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[15:0], write_data[31:16], pattern_length[44:32], last_mask[52:45]
    input  logic [55:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // first_index[16:0], hit_count[33:17]
    output logic [39:0] m_tdata,
    // status[0]
    output logic        m_tuser
);

    cmd_t        cmd;
    stat_t       stat;
    op_t         s_op;
    logic [16:0] first_index, hit_count;

    assign s_op = op_t'(s_tuser);

    sars_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_op),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sars_dp #(.TEXT_DEPTH(TEXT_DEPTH), .PATTERN_DEPTH(PATTERN_DEPTH)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_op             (s_op),
        .s_address        (s_tdata[15:0]),
        .s_write_data     (s_tdata[31:16]),
        .s_pattern_length (s_tdata[44:32]),
        .s_last_mask      (s_tdata[52:45]),
        .cmd              (cmd),
        .stat             (stat),
        .m_first_index    (first_index),
        .m_hit_count      (hit_count),
        .m_status         (m_tuser)
    );

    assign m_tdata = {6'b0, hit_count, first_index};

    // A search keeps the block busy in the cycle after its transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_op == OP_SEARCH) |=> !s_tready)
        else $error("search accepted without going busy");

    // The output register is never overwritten while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // An error result carries no range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error result with nonzero range");

endmodule
